/* rtl/core/greedy_radius_point_matcher_unit_macros.svh */
// Assertion macros shared by the point matcher RTL.
// Included by the controller and the datapath; needs nothing else.
`ifndef GREEDY_RADIUS_POINT_MATCHER_UNIT_MACROS_SVH
`define GREEDY_RADIUS_POINT_MATCHER_UNIT_MACROS_SVH

// Condition must hold on every clock out of reset.
`define GRPM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define GRPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GRPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/grpm_pkg.sv */
// Package for the greedy radius point matcher: payload types, codes,
// controller/datapath command and status structs. No dependencies.
package grpm_pkg;

  localparam int MAX_PREV_DEF = 32;
  localparam int MAX_CURR_DEF = 32;
  localparam int COORD_W      = 16;
  localparam int PT_W         = 2 * COORD_W;
  localparam int DIST_W       = 16;

  typedef logic [1:0]        opcode_t;
  typedef logic [4:0]        idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Request opcodes
  localparam opcode_t OP_LOAD_PREV = 2'd0;
  localparam opcode_t OP_LOAD_CURR = 2'd1;
  localparam opcode_t OP_RUN       = 2'd2;

  // Result kinds
  localparam logic KIND_PREV  = 1'b0;
  localparam logic KIND_TRACK = 1'b1;

  localparam dist_t DIST_RESET = 16'd1;

  typedef struct packed {
    opcode_t             opcode;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
  } in_req_t;

  typedef struct packed {
    logic result_kind;
    idx_t point_index;
    logic matched;
    idx_t partner_index;
    logic last;
  } out_req_t;

  // Controller -> datapath
  typedef struct packed {
    logic prev_wr;
    logic curr_wr;
    logic prev_rd;
    logic curr_rd;
    logic prev_cap;
    logic diff_en;
    logic sq_en;
    logic clear_match;
    logic set_match;
    logic load_res;
    logic res_kind;
    logic res_last;
    logic clear_used;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic used_bit;
    logic hit;
    logic unused_any;
    logic unused_after;
  } dp_stat_t;

endpackage

/* rtl/core/grpm_stream_if.sv */
// Valid/ready channel carrying one request payload of a given type.
// Depends on nothing; payload types come from grpm_pkg at instantiation.
interface grpm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/grpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/grpm_datapath.sv */
// Datapath: point stores, distance pipeline, used mask, result register.
// Depends on grpm_pkg, grpm_ram and the assertion macro header.
`include "greedy_radius_point_matcher_unit_macros.svh"

module grpm_datapath #(
  parameter int MAX_PREV = grpm_pkg::MAX_PREV_DEF,
  parameter int MAX_CURR = grpm_pkg::MAX_CURR_DEF,
  localparam int PA_W = (MAX_PREV > 1) ? $clog2(MAX_PREV) : 1,
  localparam int CA_W = (MAX_CURR > 1) ? $clog2(MAX_CURR) : 1,
  localparam int CC_W = $clog2(MAX_CURR + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  grpm_pkg::ctrl_cmd_t cmd,
  output grpm_pkg::dp_stat_t  stat,
  input  logic [PA_W-1:0]     prev_addr,
  input  logic [CA_W-1:0]     curr_addr,
  input  logic [CC_W-1:0]     j_idx,
  input  logic [CC_W-1:0]     curr_count,
  input  grpm_pkg::idx_t      res_index,
  input  grpm_pkg::in_req_t   in_data,
  input  logic                cfg_we,
  input  grpm_pkg::dist_t     cfg_data,
  output grpm_pkg::out_req_t  res_data
);

  logic [grpm_pkg::PT_W-1:0] wr_point;
  logic [grpm_pkg::PT_W-1:0] prev_rdata;
  logic [grpm_pkg::PT_W-1:0] curr_rdata;
  logic signed [15:0]        prev_x;
  logic signed [15:0]        prev_y;
  logic signed [16:0]        dx;
  logic signed [16:0]        dy;
  logic signed [33:0]        prod_x;
  logic signed [33:0]        prod_y;
  logic [31:0]               sq_x;
  logic [31:0]               sq_y;
  logic [32:0]               dist_sum;
  grpm_pkg::dist_t           limit;
  logic [MAX_CURR-1:0]       used;
  logic                      match_flag;
  grpm_pkg::idx_t            partner;

  // Packed point: y high, x low
  assign wr_point = {in_data.coord_y, in_data.coord_x};

  grpm_ram #(.WIDTH(grpm_pkg::PT_W), .DEPTH(MAX_PREV)) u_prev_ram (
    .clk   (clk),
    .we    (cmd.prev_wr),
    .waddr (prev_addr),
    .wdata (wr_point),
    .re    (cmd.prev_rd),
    .raddr (prev_addr),
    .rdata (prev_rdata)
  );

  grpm_ram #(.WIDTH(grpm_pkg::PT_W), .DEPTH(MAX_CURR)) u_curr_ram (
    .clk   (clk),
    .we    (cmd.curr_wr),
    .waddr (curr_addr),
    .wdata (wr_point),
    .re    (cmd.curr_rd),
    .raddr (curr_addr),
    .rdata (curr_rdata)
  );

  // Distance pipeline: hold prev point, differences, squares
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.prev_cap) begin
      prev_x <= $signed(prev_rdata[15:0]);
      prev_y <= $signed(prev_rdata[31:16]);
    end
    if (cmd.diff_en) begin
      dx <= 17'(prev_x) - 17'($signed(curr_rdata[15:0]));
      dy <= 17'(prev_y) - 17'($signed(curr_rdata[31:16]));
    end
    if (cmd.sq_en) begin
      sq_x <= prod_x[31:0];
      sq_y <= prod_y[31:0];
    end
  end

  // Squares never exceed 2^32 - 1, so a 33-bit sum is exact
  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};

  // Distance limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= grpm_pkg::DIST_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // Used mask and current match of the previous point under scan
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      match_flag <= 1'b0;
    end else begin
      if (cmd.clear_used) begin
        used <= '0;
      end else if (cmd.set_match) begin
        used[curr_addr] <= 1'b1;
      end
      if (cmd.clear_match) begin
        match_flag <= 1'b0;
      end else if (cmd.set_match) begin
        match_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_match) begin
      partner <= grpm_pkg::idx_t'(curr_addr);
    end
  end

  // Status: candidate used, distance hit, unused current points
  // (any at all, and any above the scan index)
  always_comb begin
    stat.used_bit     = used[curr_addr];
    stat.hit          = (dist_sum <= {17'd0, limit});
    stat.unused_any   = 1'b0;
    stat.unused_after = 1'b0;
    for (int k = 0; k < MAX_CURR; k++) begin
      if (k < int'(curr_count) && !used[k]) begin
        stat.unused_any = 1'b1;
        if (k > int'(j_idx)) begin
          stat.unused_after = 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res_data.result_kind   <= cmd.res_kind;
      res_data.point_index   <= res_index;
      res_data.last          <= cmd.res_last;
      if (cmd.res_kind == grpm_pkg::KIND_PREV) begin
        res_data.matched       <= match_flag;
        res_data.partner_index <= match_flag ? partner : '0;
      end else begin
        res_data.matched       <= 1'b0;
        res_data.partner_index <= '0;
      end
    end
  end

  `GRPM_ASSERT_IMPL(a_match_on_free, clk, rst, cmd.set_match, !used[curr_addr],
                    "matched a used point")
  `GRPM_ASSERT_NEXT(a_used_cleared, clk, rst, cmd.clear_used, used == '0, "used mask not cleared")

endmodule

/* rtl/core/grpm_ctrl.sv */
// Controller: list counts, scan indexes and the run sequencer.
// Depends on grpm_pkg and the assertion macro header.
`include "greedy_radius_point_matcher_unit_macros.svh"

module grpm_ctrl #(
  parameter int MAX_PREV = grpm_pkg::MAX_PREV_DEF,
  parameter int MAX_CURR = grpm_pkg::MAX_CURR_DEF,
  localparam int PA_W = (MAX_PREV > 1) ? $clog2(MAX_PREV) : 1,
  localparam int CA_W = (MAX_CURR > 1) ? $clog2(MAX_CURR) : 1,
  localparam int PC_W = $clog2(MAX_PREV + 1),
  localparam int CC_W = $clog2(MAX_CURR + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  grpm_pkg::opcode_t   in_opcode,
  output logic                res_valid,
  input  logic                res_ready,
  output grpm_pkg::ctrl_cmd_t cmd,
  input  grpm_pkg::dp_stat_t  stat,
  output logic [PA_W-1:0]     prev_addr,
  output logic [CA_W-1:0]     curr_addr,
  output logic [CC_W-1:0]     j_idx,
  output logic [CC_W-1:0]     curr_count,
  output grpm_pkg::idx_t      res_index
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREV_RD  = 4'd1;
  localparam logic [3:0] S_PREV_LAT = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_C_DIFF   = 4'd4;
  localparam logic [3:0] S_C_SQR    = 4'd5;
  localparam logic [3:0] S_C_CMP    = 4'd6;
  localparam logic [3:0] S_LOAD_P   = 4'd7;
  localparam logic [3:0] S_OUT_P    = 4'd8;
  localparam logic [3:0] S_NT_SCAN  = 4'd9;
  localparam logic [3:0] S_LOAD_N   = 4'd10;
  localparam logic [3:0] S_OUT_N    = 4'd11;

  logic [3:0]      state, state_next;
  logic [PC_W-1:0] prev_count, prev_count_next;
  logic [CC_W-1:0] curr_cnt, curr_cnt_next;
  logic [PA_W-1:0] i, i_next;
  logic [CC_W-1:0] j, j_next;
  logic            last_prev;

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_OUT_P) || (state == S_OUT_N);
  assign j_idx      = j;
  assign curr_count = curr_cnt;
  assign prev_addr  = (state == S_IDLE) ? prev_count[PA_W-1:0] : i;
  assign curr_addr  = (state == S_IDLE) ? curr_cnt[CA_W-1:0] : j[CA_W-1:0];
  assign res_index  = (state == S_LOAD_N) ? grpm_pkg::idx_t'(j) : grpm_pkg::idx_t'(i);
  assign last_prev  = (int'(i) + 1 == int'(prev_count));

  // Next state and commands
  always_comb begin
    state_next      = state;
    prev_count_next = prev_count;
    curr_cnt_next   = curr_cnt;
    i_next          = i;
    j_next          = j;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            grpm_pkg::OP_LOAD_PREV: begin
              if (prev_count < PC_W'(MAX_PREV)) begin
                cmd.prev_wr     = 1'b1;
                prev_count_next = prev_count + PC_W'(1);
              end
            end
            grpm_pkg::OP_LOAD_CURR: begin
              if (curr_cnt < CC_W'(MAX_CURR)) begin
                cmd.curr_wr   = 1'b1;
                curr_cnt_next = curr_cnt + CC_W'(1);
              end
            end
            grpm_pkg::OP_RUN: begin
              i_next     = '0;
              j_next     = '0;
              state_next = (prev_count == '0) ? S_NT_SCAN : S_PREV_RD;
            end
            default: ;
          endcase
        end
      end
      S_PREV_RD: begin
        cmd.prev_rd     = 1'b1;
        cmd.clear_match = 1'b1;
        j_next          = '0;
        state_next      = S_PREV_LAT;
      end
      S_PREV_LAT: begin
        cmd.prev_cap = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        priority if (j == curr_cnt) begin
          state_next = S_LOAD_P;
        end else if (stat.used_bit) begin
          j_next = j + CC_W'(1);
        end else begin
          cmd.curr_rd = 1'b1;
          state_next  = S_C_DIFF;
        end
      end
      S_C_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_C_SQR;
      end
      S_C_SQR: begin
        cmd.sq_en  = 1'b1;
        state_next = S_C_CMP;
      end
      S_C_CMP: begin
        if (stat.hit) begin
          cmd.set_match = 1'b1;
          state_next    = S_LOAD_P;
        end else begin
          j_next     = j + CC_W'(1);
          state_next = S_SCAN;
        end
      end
      S_LOAD_P: begin
        cmd.load_res = 1'b1;
        cmd.res_kind = grpm_pkg::KIND_PREV;
        cmd.res_last = last_prev && !stat.unused_any;
        state_next   = S_OUT_P;
      end
      S_OUT_P: begin
        if (res_ready) begin
          if (last_prev) begin
            j_next     = '0;
            state_next = S_NT_SCAN;
          end else begin
            i_next     = i + PA_W'(1);
            state_next = S_PREV_RD;
          end
        end
      end
      S_NT_SCAN: begin
        priority if (j == curr_cnt) begin
          cmd.clear_used  = 1'b1;
          prev_count_next = '0;
          curr_cnt_next   = '0;
          j_next          = '0;
          state_next      = S_IDLE;
        end else if (stat.used_bit) begin
          j_next = j + CC_W'(1);
        end else begin
          state_next = S_LOAD_N;
        end
      end
      S_LOAD_N: begin
        cmd.load_res = 1'b1;
        cmd.res_kind = grpm_pkg::KIND_TRACK;
        cmd.res_last = !stat.unused_after;
        state_next   = S_OUT_N;
      end
      S_OUT_N: begin
        if (res_ready) begin
          j_next     = j + CC_W'(1);
          state_next = S_NT_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_count <= '0;
      curr_cnt   <= '0;
      i          <= '0;
      j          <= '0;
    end else begin
      state      <= state_next;
      prev_count <= prev_count_next;
      curr_cnt   <= curr_cnt_next;
      i          <= i_next;
      j          <= j_next;
    end
  end

  `GRPM_ASSERT_ALWAYS(a_prev_bound, clk, rst, prev_count <= PC_W'(MAX_PREV),
                      "prev count overflow")
  `GRPM_ASSERT_ALWAYS(a_j_bound, clk, rst, j <= curr_cnt, "scan index past current count")
  `GRPM_ASSERT_IMPL(a_no_accept_pending, clk, rst, in_valid && in_ready, !res_valid,
                    "request taken while result pending")

endmodule

/* rtl/core/greedy_radius_point_matcher_unit.sv */
// Top level of the greedy radius point matcher.
// Depends on grpm_pkg, grpm_stream_if, grpm_ctrl and grpm_datapath.
//
// Usage:
//   cmd : request channel (opcode, coord_x, coord_y). Opcode 0 appends a
//         previous-frame point, 1 appends a current-frame point, 2 runs the
//         match. Loads into a full list and opcode 3 are dropped.
//   res : result channel. A run emits one report per previous point in load
//         order, then one per current point left unused; last marks the
//         final result. A run with both lists empty emits nothing.
//   cfg : write channel for match_dist_sq (inclusive squared distance
//         limit), always ready. Write it only while the block is idle.
// Throughput: loads are taken back to back, one per cycle. A run is
//   sequenced by the controller over the two point RAMs and one distance
//   pipeline: each candidate comparison steps through read, difference,
//   square and compare, a used candidate is skipped, each previous point
//   is read and latched, scanned (with a further scan step if the scan runs
//   off the end of the list) and its result loaded and handed over, each new
//   track is a scan step plus a result load and handshake, and the run ends
//   by clearing the lists. No request is taken during a run.
// Reset: clears both lists, the used mask and sets the limit to 1.
// Stall: a result waits in the output register until res.ready; the run
//   holds where it is meanwhile.
module greedy_radius_point_matcher_unit #(
  parameter int MAX_PREV = grpm_pkg::MAX_PREV_DEF,
  parameter int MAX_CURR = grpm_pkg::MAX_CURR_DEF
) (
  input  logic         clk,
  input  logic         rst,
  grpm_stream_if.sink   cmd,
  grpm_stream_if.source res,
  grpm_stream_if.sink   cfg
);

  localparam int PA_W = (MAX_PREV > 1) ? $clog2(MAX_PREV) : 1;
  localparam int CA_W = (MAX_CURR > 1) ? $clog2(MAX_CURR) : 1;
  localparam int CC_W = $clog2(MAX_CURR + 1);

  grpm_pkg::ctrl_cmd_t ctl;
  grpm_pkg::dp_stat_t  stat;
  logic [PA_W-1:0]     prev_addr;
  logic [CA_W-1:0]     curr_addr;
  logic [CC_W-1:0]     j_idx;
  logic [CC_W-1:0]     curr_count;
  grpm_pkg::idx_t      res_index;

  // Limit register takes every write
  assign cfg.ready = 1'b1;

  grpm_ctrl #(.MAX_PREV(MAX_PREV), .MAX_CURR(MAX_CURR)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_ready   (cmd.ready),
    .in_opcode  (cmd.data.opcode),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .cmd        (ctl),
    .stat       (stat),
    .prev_addr  (prev_addr),
    .curr_addr  (curr_addr),
    .j_idx      (j_idx),
    .curr_count (curr_count),
    .res_index  (res_index)
  );

  grpm_datapath #(.MAX_PREV(MAX_PREV), .MAX_CURR(MAX_CURR)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl),
    .stat       (stat),
    .prev_addr  (prev_addr),
    .curr_addr  (curr_addr),
    .j_idx      (j_idx),
    .curr_count (curr_count),
    .res_index  (res_index),
    .in_data    (cmd.data),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.data),
    .res_data   (res.data)
  );

endmodule

/* tb/grpm_match_checker.sv */
// Scoreboard for the greedy radius point matcher: mirrors the point lists and
// the distance limit, predicts every run's reports and compares them.
// Depends on grpm_pkg only; sees the channels as plain signals.
`timescale 1ns / 100ps

module grpm_match_checker
  import grpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  logic     cmd_ready,
  input  in_req_t  cmd_data,
  input  logic     res_valid,
  input  logic     res_ready,
  input  out_req_t res_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  dist_t    cfg_data,
  output int       fail_count,
  output int       pending
);

  // Mirror of the block's lists and limit
  logic signed [COORD_W-1:0] prev_x [MAX_PREV_DEF];
  logic signed [COORD_W-1:0] prev_y [MAX_PREV_DEF];
  logic signed [COORD_W-1:0] curr_x [MAX_CURR_DEF];
  logic signed [COORD_W-1:0] curr_y [MAX_CURR_DEF];
  int    prev_n;
  int    curr_n;
  dist_t limit_sq;
  int    errs;

  out_req_t match_reports [$];

  // Exact squared distance, wide enough that it never wraps
  function automatic longint pair_dist_sq(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  // Greedy first fit over the lists, then queue the reports of the run
  task automatic predict_matches();
    logic [31:0] taken;
    int          partner [MAX_PREV_DEF];
    int          total;
    int          k;
    out_req_t    r;
    taken = '0;
    for (int i = 0; i < prev_n; i++) begin
      partner[i] = -1;
      for (int j = 0; j < curr_n; j++) begin
        if (!taken[j] &&
            pair_dist_sq(prev_x[i], prev_y[i], curr_x[j], curr_y[j]) <= longint'(limit_sq)) begin
          taken[j]   = 1'b1;
          partner[i] = j;
          break;
        end
      end
    end
    total = prev_n + curr_n - $countones(taken);
    k = 0;
    for (int i = 0; i < prev_n; i++) begin
      r.result_kind   = KIND_PREV;
      r.point_index   = idx_t'(i);
      r.matched       = (partner[i] >= 0);
      r.partner_index = (partner[i] >= 0) ? idx_t'(partner[i]) : idx_t'(0);
      r.last          = (k == total - 1);
      match_reports   = {match_reports, r};
      k++;
    end
    for (int j = 0; j < curr_n; j++) begin
      if (!taken[j]) begin
        r.result_kind   = KIND_TRACK;
        r.point_index   = idx_t'(j);
        r.matched       = 1'b0;
        r.partner_index = idx_t'(0);
        r.last          = (k == total - 1);
        match_reports   = {match_reports, r};
        k++;
      end
    end
    prev_n = 0;
    curr_n = 0;
  endtask

  task automatic note_failure(string msg);
    errs++;
    if (errs <= 10) $display("%0t checker: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      prev_n     = 0;
      curr_n     = 0;
      limit_sq   = DIST_RESET;
      errs       = 0;
      match_reports.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // Result side: compare with the oldest prediction
      if (res_valid && res_ready) begin
        if (match_reports.size() == 0) begin
          note_failure($sformatf("unexpected result kind=%0d idx=%0d m=%0d p=%0d last=%0d",
                                 res_data.result_kind, res_data.point_index, res_data.matched,
                                 res_data.partner_index, res_data.last));
        end else begin
          want = match_reports.pop_front();
          if (res_data.result_kind !== want.result_kind ||
              res_data.point_index !== want.point_index ||
              res_data.matched !== want.matched ||
              res_data.partner_index !== want.partner_index ||
              res_data.last !== want.last) begin
            note_failure($sformatf({"mismatch exp kind=%0d idx=%0d m=%0d p=%0d last=%0d",
                                    " got kind=%0d idx=%0d m=%0d p=%0d last=%0d"},
                                   want.result_kind, want.point_index, want.matched,
                                   want.partner_index, want.last,
                                   res_data.result_kind, res_data.point_index, res_data.matched,
                                   res_data.partner_index, res_data.last));
          end
        end
      end

      // Limit register write
      if (cfg_valid && cfg_ready) limit_sq = cfg_data;

      // Request side: loads, runs, dropped requests
      if (cmd_valid && cmd_ready) begin
        case (cmd_data.opcode)
          OP_LOAD_PREV: begin
            if (prev_n < MAX_PREV_DEF) begin
              prev_x[prev_n] = cmd_data.coord_x;
              prev_y[prev_n] = cmd_data.coord_y;
              prev_n++;
            end
          end
          OP_LOAD_CURR: begin
            if (curr_n < MAX_CURR_DEF) begin
              curr_x[curr_n] = cmd_data.coord_x;
              curr_y[curr_n] = cmd_data.coord_y;
              curr_n++;
            end
          end
          OP_RUN: predict_matches();
          default: ;
        endcase
      end

      fail_count <= errs;
      pending    <= match_reports.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the point matcher testbench: clock, reset, request and limit stimulus,
// result back-pressure and the verdict. Depends on grpm_pkg, grpm_stream_if,
// the matcher RTL and grpm_match_checker.
`timescale 1ns / 100ps

module tb_top;
  import grpm_pkg::*;

  localparam int      TARGET_ITEMS = 450;
  localparam opcode_t OP_UNUSED    = 2'd3;

  logic clk;
  logic rst;

  grpm_stream_if #(.payload_t(in_req_t))  cmd_if ();
  grpm_stream_if #(.payload_t(out_req_t)) res_if ();
  grpm_stream_if #(.payload_t(dist_t))    cfg_if ();

  int    fail_count;
  int    pending;
  int    send_pct;
  int    stall_pct;
  int    items_sent;
  dist_t cur_limit;

  // Previous points of the sequence being loaded, to aim current points at
  logic signed [15:0] seq_px [$];
  logic signed [15:0] seq_py [$];

  greedy_radius_point_matcher_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  grpm_match_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_if.valid),
    .cmd_ready  (cmd_if.ready),
    .cmd_data   (cmd_if.data),
    .res_valid  (res_if.valid),
    .res_ready  (res_if.ready),
    .res_data   (res_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly small coordinates, a quarter over the full 16-bit range
  function automatic logic signed [15:0] pick_coord();
    if ($urandom_range(99) < 25) return 16'($urandom);
    return 16'(int'($urandom_range(200)) - 100);
  endfunction

  // One request, held until accepted, then an optional idle gap
  task automatic send_req(opcode_t op, logic signed [15:0] x, logic signed [15:0] y);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= '{opcode: op, coord_x: x, coord_y: y};
    do @(posedge clk); while (!cmd_if.ready);
    items_sent++;
    if ($urandom_range(99) < send_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  // Hold off requests until every predicted report is back and the run has wound down
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !cmd_if.ready) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(dist_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_limit = v;
    @(posedge clk);
  endtask

  // Random interleaved loads; current points mostly near a loaded previous point
  task automatic load_sequence(int n_prev, int n_curr, bit do_run);
    int                 left_p;
    int                 left_c;
    int                 k;
    int                 span;
    int                 ox;
    int                 oy;
    logic signed [15:0] x;
    logic signed [15:0] y;
    left_p = n_prev;
    left_c = n_curr;
    span = (cur_limit >= 1000) ? 150 : 3;
    seq_px.delete();
    seq_py.delete();
    while (left_p + left_c > 0) begin
      if ($urandom_range(99) < 4) send_req(OP_UNUSED, pick_coord(), pick_coord());
      if (left_p > 0 && (left_c == 0 || seq_px.size() == 0 || $urandom_range(1) == 1)) begin
        x = pick_coord();
        y = pick_coord();
        send_req(OP_LOAD_PREV, x, y);
        seq_px = {seq_px, x};
        seq_py = {seq_py, y};
        left_p--;
      end else begin
        if (seq_px.size() > 0 && $urandom_range(99) < 70) begin
          k  = $urandom_range(seq_px.size() - 1);
          ox = int'($urandom_range(2 * span)) - span;
          oy = int'($urandom_range(2 * span)) - span;
          x  = seq_px[k] + 16'(ox);
          y  = seq_py[k] + 16'(oy);
        end else begin
          x = pick_coord();
          y = pick_coord();
        end
        send_req(OP_LOAD_CURR, x, y);
        left_c--;
      end
    end
    if (do_run) send_req(OP_RUN, pick_coord(), pick_coord());
  endtask

  initial begin
    int phase;
    int seq_no;
    int n_prev;
    int n_curr;
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    send_pct     = 0;
    stall_pct    = 0;
    items_sent   = 0;
    cur_limit    = DIST_RESET;

    // Result back-pressure
    fork
      forever begin
        @(posedge clk);
        res_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
      end
    join_none

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty run, dropped opcode, corner coordinates at the reset limit
    send_req(OP_RUN, 0, 0);
    send_req(OP_UNUSED, -1, -1);
    send_req(OP_LOAD_PREV, 0, 0);
    send_req(OP_LOAD_PREV, -32768, -32768);
    send_req(OP_LOAD_PREV, 32767, 32767);
    send_req(OP_LOAD_CURR, 1, 1);
    send_req(OP_LOAD_CURR, 1, 0);
    send_req(OP_LOAD_CURR, 32767, 32767);
    send_req(OP_LOAD_CURR, -32768, 32767);
    send_req(OP_RUN, 0, 0);
    wait_drained();

    // Widest limit: 256 just outside, 255 and 181/181 just inside; first fit wins
    write_limit(16'hFFFF);
    send_req(OP_LOAD_PREV, 0, 0);
    send_req(OP_LOAD_PREV, 0, 0);
    send_req(OP_LOAD_CURR, 256, 0);
    send_req(OP_LOAD_CURR, 255, 0);
    send_req(OP_LOAD_CURR, 181, -181);
    send_req(OP_RUN, 0, 0);
    wait_drained();

    // Zero limit: only identical points pair; then one-sided runs
    write_limit(16'h0000);
    send_req(OP_LOAD_PREV, -5, 7);
    send_req(OP_LOAD_CURR, -5, 7);
    send_req(OP_LOAD_CURR, -32768, -32768);
    send_req(OP_RUN, 0, 0);
    send_req(OP_LOAD_CURR, 100, -100);
    send_req(OP_RUN, 0, 0);
    send_req(OP_LOAD_PREV, 3, 3);
    send_req(OP_RUN, 0, 0);
    wait_drained();

    // Random phases, each with its own limit and idling pattern
    phase  = 0;
    seq_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase % 8)
        0: write_limit(DIST_RESET);
        1: write_limit(16'hFFFF);
        2: write_limit(16'h0000);
        3: write_limit(dist_t'($urandom));
        4: write_limit(16'd2);
        5: write_limit(dist_t'($urandom_range(3, 400)));
        6: write_limit(16'hFFFF);
        default: write_limit(dist_t'($urandom_range(0, 20)));
      endcase
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 49; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 49; end
        default: begin send_pct = 14; stall_pct = 14; end
      endcase
      for (int s = 0; s < 6; s++) begin
        if (seq_no % 25 == 5) begin
          n_prev = $urandom_range(32, 34);
          n_curr = $urandom_range(32, 34);
        end else begin
          n_prev = $urandom_range(0, 6);
          n_curr = $urandom_range(0, 6);
        end
        load_sequence(n_prev, n_curr, $urandom_range(9) != 0);
        seq_no++;
        // Sender holds off mid-phase until the block has drained
        if (s == 3 && phase % 3 == 1) wait_drained();
      end
      send_req(OP_RUN, pick_coord(), pick_coord());
      wait_drained();
      phase++;
    end

    stall_pct = 0;
    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
